>>> sv/half_rgba_to_unorm8_pixel_core_defines.svh
// Assertion macros used by the checker file.
`ifndef HALF_RGBA_TO_UNORM8_PIXEL_CORE_DEFINES_SVH
`define HALF_RGBA_TO_UNORM8_PIXEL_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HRGBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HRGBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/hrgba_pkg.sv
package hrgba_pkg;

  localparam int unsigned HalfW   = 16;
  localparam int unsigned UnormW  = 8;
  localparam int unsigned FracBits = 26;
  localparam int unsigned FixW    = FracBits + 1;   // clamped value, [0, 1.0]
  localparam int unsigned MagW    = FracBits + 3;   // magnitude, up to 4.0
  localparam int unsigned SgnW    = MagW + 2;       // signed, with remap headroom
  localparam int unsigned ProdW   = FracBits + UnormW;

  localparam logic [4:0]  ExpMax    = 5'h1F;
  localparam logic [4:0]  ExpSatMin = 5'd17;
  localparam logic [9:0]  ManMask   = 10'h3FF;
  localparam logic [MagW-1:0] SatFix = MagW'(1) << (FracBits + 2);
  localparam logic signed [SgnW-1:0] OneSgn = SgnW'(1) << FracBits;
  localparam logic [FixW-1:0] OneFix = FixW'(1) << FracBits;
  localparam logic [ProdW-1:0] HalfFix = ProdW'(1) << (FracBits - 1);
  localparam logic [UnormW-1:0] UnormMax = 8'd255;

  typedef struct packed {
    logic background;
    logic last;
  } ctrl_t;

endpackage

>>> sv/half_rgba_to_unorm8_pixel_core.sv
// Half-float RGBA to 8-bit unorm pixel converter. Accepts one pixel per clock
// while not stalled by back-pressure: four lanes decode, optionally remap and
// clamp each channel into a stage register, then scale by 255 with rounding
// into the output register, where the background and alpha rules are applied.
// A pixel whose red, green and blue words are all zero is background and
// converts all four channels as they are; any other pixel has alpha forced
// to 255 and, when remap_signed is set, colors mapped from [-1,1] to [0,1].
// NaN gives 0, infinities saturate. Back-pressure on the output holds the
// output register; a new pixel is still taken while a result waits, as long
// as the stage register is free. Write remap_signed only while idle.
module half_rgba_to_unorm8_pixel_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          remap_signed_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hrgba_pkg::HalfW-1:0]   red_half_i,
  input  logic [hrgba_pkg::HalfW-1:0]   green_half_i,
  input  logic [hrgba_pkg::HalfW-1:0]   blue_half_i,
  input  logic [hrgba_pkg::HalfW-1:0]   alpha_half_i,
  input  logic                          last_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hrgba_pkg::UnormW-1:0]  red_out_o,
  output logic [hrgba_pkg::UnormW-1:0]  green_out_o,
  output logic [hrgba_pkg::UnormW-1:0]  blue_out_o,
  output logic [hrgba_pkg::UnormW-1:0]  alpha_out_o,
  output logic                          last_out_o
);

  logic                          remap_q;
  logic                          s1_valid_d, s1_valid_q;
  logic                          merge_ready;
  logic                          advance;
  logic                          background;
  logic                          color_remap;
  hrgba_pkg::ctrl_t              ctrl_d, ctrl_q;
  logic [hrgba_pkg::UnormW-1:0]  red_code, green_code, blue_code, alpha_code;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remap_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      remap_q <= remap_signed_i;
    end
  end

  assign background  = (red_half_i == '0) && (green_half_i == '0) && (blue_half_i == '0);
  assign color_remap = remap_q && !background;
  assign advance     = !s1_valid_q || merge_ready;
  assign in_ready_o  = advance;

  always_comb begin
    ctrl_d.background = background;
    ctrl_d.last       = last_pixel_i;
    s1_valid_d        = s1_valid_q;
    if (advance) begin
      s1_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctrl_q <= ctrl_d;
    end
  end

  hrgba_lane u_lane_red (
    .clk_i   (clk_i),
    .en_i    (advance),
    .half_i  (red_half_i),
    .remap_i (color_remap),
    .code_o  (red_code)
  );

  hrgba_lane u_lane_green (
    .clk_i   (clk_i),
    .en_i    (advance),
    .half_i  (green_half_i),
    .remap_i (color_remap),
    .code_o  (green_code)
  );

  hrgba_lane u_lane_blue (
    .clk_i   (clk_i),
    .en_i    (advance),
    .half_i  (blue_half_i),
    .remap_i (color_remap),
    .code_o  (blue_code)
  );

  hrgba_lane u_lane_alpha (
    .clk_i   (clk_i),
    .en_i    (advance),
    .half_i  (alpha_half_i),
    .remap_i (1'b0),
    .code_o  (alpha_code)
  );

  hrgba_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s1_valid_q),
    .red_code_i   (red_code),
    .green_code_i (green_code),
    .blue_code_i  (blue_code),
    .alpha_code_i (alpha_code),
    .ctrl_i       (ctrl_q),
    .ready_o      (merge_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .alpha_out_o  (alpha_out_o),
    .last_out_o   (last_out_o)
  );

endmodule

>>> sv/hrgba_lane.sv
module hrgba_lane (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [hrgba_pkg::HalfW-1:0]        half_i,
  input  logic                               remap_i,
  output logic [hrgba_pkg::UnormW-1:0]       code_o
);

  logic [4:0]                            ex;
  logic [9:0]                            man;
  logic                                  is_nan;
  logic [hrgba_pkg::MagW-1:0]            mag;
  logic signed [hrgba_pkg::SgnW-1:0]     sv;
  logic signed [hrgba_pkg::SgnW-1:0]     rv;
  logic [hrgba_pkg::FixW-1:0]            v_d, v_q;
  logic [hrgba_pkg::ProdW-1:0]           prod;

  always_comb begin
    ex     = half_i[14:10];
    man    = half_i[9:0] & hrgba_pkg::ManMask;
    is_nan = (ex == hrgba_pkg::ExpMax) && (man != '0);
    if (ex == hrgba_pkg::ExpMax || ex >= hrgba_pkg::ExpSatMin) begin
      mag = hrgba_pkg::SatFix;
    end else if (ex == '0) begin
      mag = hrgba_pkg::MagW'({man, 2'b00});
    end else begin
      mag = hrgba_pkg::MagW'({1'b1, man}) << (ex + 5'd1);
    end
    if (is_nan) begin
      sv = '0;
    end else if (half_i[15]) begin
      sv = -$signed({2'b00, mag});
    end else begin
      sv = $signed({2'b00, mag});
    end
    // NaN stays 0 even when remapped
    if (remap_i && !is_nan) begin
      rv = (sv + hrgba_pkg::OneSgn) >>> 1;
    end else begin
      rv = sv;
    end
    if (rv < 0) begin
      v_d = '0;
    end else if (rv > $signed({4'b0000, hrgba_pkg::OneFix})) begin
      v_d = hrgba_pkg::OneFix;
    end else begin
      v_d = rv[hrgba_pkg::FixW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
    end
  end

  assign prod = hrgba_pkg::ProdW'(v_q) * hrgba_pkg::ProdW'(hrgba_pkg::UnormMax)
              + hrgba_pkg::HalfFix;
  assign code_o = prod[hrgba_pkg::ProdW-1:hrgba_pkg::FracBits];

endmodule

>>> sv/hrgba_merge.sv
module hrgba_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [hrgba_pkg::UnormW-1:0]  red_code_i,
  input  logic [hrgba_pkg::UnormW-1:0]  green_code_i,
  input  logic [hrgba_pkg::UnormW-1:0]  blue_code_i,
  input  logic [hrgba_pkg::UnormW-1:0]  alpha_code_i,
  input  hrgba_pkg::ctrl_t              ctrl_i,
  output logic                          ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hrgba_pkg::UnormW-1:0]  red_out_o,
  output logic [hrgba_pkg::UnormW-1:0]  green_out_o,
  output logic [hrgba_pkg::UnormW-1:0]  blue_out_o,
  output logic [hrgba_pkg::UnormW-1:0]  alpha_out_o,
  output logic                          last_out_o
);

  logic                          valid_d, valid_q;
  logic [hrgba_pkg::UnormW-1:0]  alpha_d;
  logic                          take;
  logic [hrgba_pkg::UnormW-1:0]  red_q, green_q, blue_q, alpha_q;
  logic                          last_q;

  assign ready_o = !valid_q || out_ready_i;
  assign take    = load_i && ready_o;
  assign alpha_d = ctrl_i.background ? alpha_code_i : hrgba_pkg::UnormMax;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      red_q   <= red_code_i;
      green_q <= green_code_i;
      blue_q  <= blue_code_i;
      alpha_q <= alpha_d;
      last_q  <= ctrl_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign alpha_out_o = alpha_q;
  assign last_out_o  = last_q;

endmodule

>>> sv/hrgba_checker.sv
`include "half_rgba_to_unorm8_pixel_core_defines.svh"

module hrgba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [hrgba_pkg::UnormW-1:0]  red_out_o,
  input logic [hrgba_pkg::UnormW-1:0]  green_out_o,
  input logic [hrgba_pkg::UnormW-1:0]  blue_out_o,
  input logic [hrgba_pkg::UnormW-1:0]  alpha_out_o,
  input logic                          last_out_o
);

  // stalled result holds
  `HRGBA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o) && $stable(alpha_out_o) && $stable(last_out_o), "stalled result changed")

  // input only stalls when both stages are full and the output is held
  `HRGBA_ASSERT_IMP(a_in_stall, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without output back-pressure")

  // a transfer reaches the output register in the cycle after it moves on
  `HRGBA_ASSERT_NXT(a_latency, clk_i, rst_ni, (in_valid_i && in_ready_o) ##1 out_ready_i, out_valid_o, "accepted pixel did not reach the output")

  // alpha is only below 255 for background pixels, whose colors are zero
  `HRGBA_ASSERT_IMP(a_bg_alpha, clk_i, rst_ni, out_valid_o && (alpha_out_o != hrgba_pkg::UnormMax), (red_out_o == '0) && (green_out_o == '0) && (blue_out_o == '0), "non-background pixel with alpha below 255")

endmodule

bind half_rgba_to_unorm8_pixel_core hrgba_checker u_hrgba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_out_o   (red_out_o),
  .green_out_o (green_out_o),
  .blue_out_o  (blue_out_o),
  .alpha_out_o (alpha_out_o),
  .last_out_o  (last_out_o)
);
